@@ design/ercov_pkg.sv @@
// Package: payload words, fixed-point constants and helpers for the rotation covariance block
`timescale 1ns / 1ps
package ercov_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CW = 34;
  localparam int LAT_FIXED = 13;

  localparam logic signed [CW-1:0] CORDIC_INIT = 34'sd652032874;
  localparam logic signed [63:0]   HALF_Q30    = 64'sd536870912;
  localparam logic signed [31:0]   ONE_Q30     = 32'sd1073741824;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef logic signed [31:0] q30_t;
  typedef logic [8:0][31:0] mat_t;

  typedef struct packed {
    logic signed [15:0] heading_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic [31:0]        heading_variance;
    logic [31:0]        pitch_variance;
    logic [31:0]        roll_variance;
    logic signed [31:0] vec_in_x;
    logic signed [31:0] vec_in_y;
    logic signed [31:0] vec_in_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] vec_out_x;
    logic signed [31:0] vec_out_y;
    logic signed [31:0] vec_out_z;
    logic signed [47:0] cov_00;
    logic signed [47:0] cov_01;
    logic signed [47:0] cov_02;
    logic signed [47:0] cov_10;
    logic signed [47:0] cov_11;
    logic signed [47:0] cov_12;
    logic signed [47:0] cov_20;
    logic signed [47:0] cov_21;
    logic signed [47:0] cov_22;
  } out_word_t;

  function automatic q30_t clamp_q30(input logic signed [CW-1:0] v);
    q30_t r;
    if (v > CW'(ONE_Q30)) begin
      r = ONE_Q30;
    end else if (v < -CW'(ONE_Q30)) begin
      r = -ONE_Q30;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic q30_t rnd_clamp(input logic signed [63:0] acc);
    logic signed [63:0] r;
    q30_t o;
    r = (acc + HALF_Q30) >>> 30;
    if (r > 64'sd1073741824) begin
      o = ONE_Q30;
    end else if (r < -64'sd1073741824) begin
      o = -ONE_Q30;
    end else begin
      o = r[31:0];
    end
    return o;
  endfunction

  function automatic mat_t rot1(input q30_t c, input q30_t s);
    return {c, -s, 32'(0), s, c, 32'(0), 32'(0), 32'(0), ONE_Q30};
  endfunction

  function automatic mat_t rot2(input q30_t c, input q30_t s);
    return {c, 32'(0), -s, 32'(0), ONE_Q30, 32'(0), s, 32'(0), c};
  endfunction

  function automatic mat_t rot3(input q30_t c, input q30_t s);
    return {ONE_Q30, 32'(0), 32'(0), 32'(0), c, -s, 32'(0), s, c};
  endfunction

  function automatic mat_t drot1(input q30_t c, input q30_t s);
    return {-s, -c, 32'(0), c, -s, 32'(0), 32'(0), 32'(0), 32'(0)};
  endfunction

  function automatic mat_t drot2(input q30_t c, input q30_t s);
    return {-s, 32'(0), -c, 32'(0), 32'(0), 32'(0), c, 32'(0), -s};
  endfunction

  function automatic mat_t drot3(input q30_t c, input q30_t s);
    return {32'(0), 32'(0), 32'(0), 32'(0), -s, -c, 32'(0), c, -s};
  endfunction

endpackage

@@ design/euler_rotation_error_covariance_top.sv @@
// Euler-angle rotation of a vector with first-order error covariance, pipelined
//
// Input channel in_valid / in_stall / in_data carries one word per attitude sample:
// three binary angles, three angle variances and a Q16.16 vector. The result
// channel out_valid / out_stall / out_data returns one word per sample: the
// rotated vector and the 3x3 covariance, both saturated.
// One word is accepted every cycle while in_stall is low. The depth is set by
// the CORDIC stage chain and a sign-fix stage, two matrix products and the
// matrix-vector product, each a multiply and a sum stage, then the
// covariance partial-product, merge, variance and rounding stages.
// The whole pipeline advances together: when the output word is held by
// out_stall, in_stall rises in the same cycle and no word is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; the pipeline is empty
// afterwards and accepts a word in the next cycle.
`timescale 1ns / 1ps
module euler_rotation_error_covariance_top #(
  parameter int CORDIC_STAGES = ercov_pkg::CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ercov_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ercov_pkg::out_word_t out_data
);
  import ercov_pkg::*;

  localparam int N   = CORDIC_STAGES;
  localparam int LAT = N + LAT_FIXED;
  localparam int PI_TAB [6] = '{0, 0, 0, 1, 1, 2};
  localparam int PJ_TAB [6] = '{0, 1, 2, 1, 2, 2};
  localparam int PIDX [9]   = '{0, 1, 2, 1, 3, 4, 2, 4, 5};
  localparam logic signed [63:0] V32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] V32_MIN = -64'sd2147483648;
  localparam logic signed [58:0] C48_MAX = 59'sd140737488355327;
  localparam logic signed [58:0] C48_MIN = -59'sd140737488355328;

  logic           adv;
  logic [LAT-1:0] vld_r;

  assign adv       = !vld_r[LAT-1] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // angle fold
  logic signed [15:0] ang  [3];
  logic signed [16:0] fold [3];
  logic               fneg [3];

  always_comb begin
    ang[0] = in_data.heading_angle;
    ang[1] = in_data.pitch_angle;
    ang[2] = in_data.roll_angle;
    for (int a = 0; a < 3; a++) begin
      if (ang[a] > 16'sd16384) begin
        fold[a] = 17'(ang[a]) - 17'sd32768;
        fneg[a] = 1'b1;
      end else if (ang[a] < -16'sd16384) begin
        fold[a] = 17'(ang[a]) + 17'sd32768;
        fneg[a] = 1'b1;
      end else begin
        fold[a] = 17'(ang[a]);
        fneg[a] = 1'b0;
      end
    end
  end

  // CORDIC chain
  logic signed [CW-1:0] x_r   [N+1][3];
  logic signed [CW-1:0] y_r   [N+1][3];
  logic signed [CW-1:0] z_r   [N+1][3];
  logic                 neg_r [N+1][3];
  logic [31:0]          var_r [N+1][3];
  logic signed [31:0]   vec_r [N+1][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        x_r[0][a]   <= CORDIC_INIT;
        y_r[0][a]   <= '0;
        z_r[0][a]   <= CW'(fold[a]) <<< 16;
        neg_r[0][a] <= fneg[a];
      end
      var_r[0][0] <= in_data.heading_variance;
      var_r[0][1] <= in_data.pitch_variance;
      var_r[0][2] <= in_data.roll_variance;
      vec_r[0][0] <= in_data.vec_in_x;
      vec_r[0][1] <= in_data.vec_in_y;
      vec_r[0][2] <= in_data.vec_in_z;
      for (int i = 0; i < N; i++) begin
        for (int a = 0; a < 3; a++) begin
          if (!z_r[i][a][CW-1]) begin
            x_r[i+1][a] <= x_r[i][a] - (y_r[i][a] >>> i);
            y_r[i+1][a] <= y_r[i][a] + (x_r[i][a] >>> i);
            z_r[i+1][a] <= z_r[i][a] - $signed({2'b00, ATAN_TAB[i]});
          end else begin
            x_r[i+1][a] <= x_r[i][a] + (y_r[i][a] >>> i);
            y_r[i+1][a] <= y_r[i][a] - (x_r[i][a] >>> i);
            z_r[i+1][a] <= z_r[i][a] + $signed({2'b00, ATAN_TAB[i]});
          end
          neg_r[i+1][a] <= neg_r[i][a];
          var_r[i+1][a] <= var_r[i][a];
          vec_r[i+1][a] <= vec_r[i][a];
        end
      end
    end
  end

  // sign fix and clamp
  q30_t               cc_r [3];
  q30_t               ss_r [3];
  logic [31:0]        var_c_r [3];
  logic signed [31:0] vec_c_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        cc_r[a]    <= clamp_q30(neg_r[N][a] ? -x_r[N][a] : x_r[N][a]);
        ss_r[a]    <= clamp_q30(neg_r[N][a] ? -y_r[N][a] : y_r[N][a]);
        var_c_r[a] <= var_r[N][a];
        vec_c_r[a] <= vec_r[N][a];
      end
    end
  end

  // first matrix products: dP3*P1, P3*dP1, P3*P1
  mat_t a1 [3];
  mat_t b1 [3];

  always_comb begin
    a1[0] = drot3(cc_r[0], ss_r[0]);
    b1[0] = rot1(cc_r[1], ss_r[1]);
    a1[1] = rot3(cc_r[0], ss_r[0]);
    b1[1] = drot1(cc_r[1], ss_r[1]);
    a1[2] = rot3(cc_r[0], ss_r[0]);
    b1[2] = rot1(cc_r[1], ss_r[1]);
  end

  logic signed [63:0] pm1_r [3][9][3];
  q30_t               rc_1p_r, rs_1p_r;
  logic [31:0]        var_1p_r [3];
  logic signed [31:0] vec_1p_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int m = 0; m < 3; m++) begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
              pm1_r[m][i*3+j][k] <= $signed(a1[m][i*3+k]) * $signed(b1[m][k*3+j]);
            end
          end
        end
      end
      rc_1p_r  <= cc_r[2];
      rs_1p_r  <= ss_r[2];
      var_1p_r <= var_c_r;
      vec_1p_r <= vec_c_r;
    end
  end

  mat_t               t_r [3];
  q30_t               rc_1s_r, rs_1s_r;
  logic [31:0]        var_1s_r [3];
  logic signed [31:0] vec_1s_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int m = 0; m < 3; m++) begin
        for (int e = 0; e < 9; e++) begin
          t_r[m][e] <= rnd_clamp(pm1_r[m][e][0] + pm1_r[m][e][1] + pm1_r[m][e][2]);
        end
      end
      rc_1s_r  <= rc_1p_r;
      rs_1s_r  <= rs_1p_r;
      var_1s_r <= var_1p_r;
      vec_1s_r <= vec_1p_r;
    end
  end

  // second matrix products: J1, J2, J3, R
  mat_t a2 [4];
  mat_t b2 [4];

  always_comb begin
    a2[0] = t_r[0];
    a2[1] = t_r[1];
    a2[2] = t_r[2];
    a2[3] = t_r[2];
    b2[0] = rot2(rc_1s_r, rs_1s_r);
    b2[1] = rot2(rc_1s_r, rs_1s_r);
    b2[2] = drot2(rc_1s_r, rs_1s_r);
    b2[3] = rot2(rc_1s_r, rs_1s_r);
  end

  logic signed [63:0] pm2_r [4][9][3];
  logic [31:0]        var_2p_r [3];
  logic signed [31:0] vec_2p_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int m = 0; m < 4; m++) begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
              pm2_r[m][i*3+j][k] <= $signed(a2[m][i*3+k]) * $signed(b2[m][k*3+j]);
            end
          end
        end
      end
      var_2p_r <= var_1s_r;
      vec_2p_r <= vec_1s_r;
    end
  end

  mat_t               j_r [4];
  logic [31:0]        var_2s_r [3];
  logic signed [31:0] vec_2s_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int m = 0; m < 4; m++) begin
        for (int e = 0; e < 9; e++) begin
          j_r[m][e] <= rnd_clamp(pm2_r[m][e][0] + pm2_r[m][e][1] + pm2_r[m][e][2]);
        end
      end
      var_2s_r <= var_2p_r;
      vec_2s_r <= vec_2p_r;
    end
  end

  // matrix-vector products
  logic signed [63:0] pv_r [4][3][3];
  logic [31:0]        var_vp_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int m = 0; m < 4; m++) begin
        for (int i = 0; i < 3; i++) begin
          for (int k = 0; k < 3; k++) begin
            pv_r[m][i][k] <= $signed(j_r[m][i*3+k]) * vec_2s_r[k];
          end
        end
      end
      var_vp_r <= var_2s_r;
    end
  end

  logic signed [63:0] mv_sum [4][3];
  logic signed [35:0] u_r  [3][3];
  logic signed [31:0] rv_r [3];
  logic [31:0]        var_vs_r [3];

  always_comb begin
    for (int m = 0; m < 4; m++) begin
      for (int i = 0; i < 3; i++) begin
        mv_sum[m][i] = (pv_r[m][i][0] + pv_r[m][i][1] + pv_r[m][i][2] + HALF_Q30) >>> 30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int m = 0; m < 3; m++) begin
        for (int i = 0; i < 3; i++) begin
          u_r[m][i] <= mv_sum[m][i][35:0];
        end
      end
      for (int i = 0; i < 3; i++) begin
        if (mv_sum[3][i] > V32_MAX) begin
          rv_r[i] <= V32_MAX[31:0];
        end else if (mv_sum[3][i] < V32_MIN) begin
          rv_r[i] <= V32_MIN[31:0];
        end else begin
          rv_r[i] <= mv_sum[3][i][31:0];
        end
      end
      var_vs_r <= var_vp_r;
    end
  end

  // covariance terms: |ui|*|uj| in two partial products
  logic [34:0] mag_a [3][6];
  logic [34:0] mag_b [3][6];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int p = 0; p < 6; p++) begin
        mag_a[k][p] = u_r[k][PI_TAB[p]][35] ? 35'(-u_r[k][PI_TAB[p]])
                                            : 35'(u_r[k][PI_TAB[p]]);
        mag_b[k][p] = u_r[k][PJ_TAB[p]][35] ? 35'(-u_r[k][PJ_TAB[p]])
                                            : 35'(u_r[k][PJ_TAB[p]]);
      end
    end
  end

  logic [52:0]        plo_a_r [3][6];
  logic [51:0]        phi_a_r [3][6];
  logic               neg_a_r [3][6];
  logic [31:0]        var_a_r [3];
  logic signed [31:0] rv_a_r  [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        for (int p = 0; p < 6; p++) begin
          plo_a_r[k][p] <= 53'(mag_a[k][p]) * 53'(mag_b[k][p][17:0]);
          phi_a_r[k][p] <= 52'(mag_a[k][p]) * 52'(mag_b[k][p][34:18]);
          neg_a_r[k][p] <= u_r[k][PI_TAB[p]][35] ^ u_r[k][PJ_TAB[p]][35];
        end
      end
      var_a_r <= var_vs_r;
      rv_a_r  <= rv_r;
    end
  end

  logic [69:0]        p_b_r   [3][6];
  logic               neg_b_r [3][6];
  logic [31:0]        var_b_r [3];
  logic signed [31:0] rv_b_r  [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        for (int p = 0; p < 6; p++) begin
          p_b_r[k][p]   <= 70'(plo_a_r[k][p]) + (70'(phi_a_r[k][p]) << 18);
          neg_b_r[k][p] <= neg_a_r[k][p];
        end
      end
      var_b_r <= var_a_r;
      rv_b_r  <= rv_a_r;
    end
  end

  logic [55:0]        pp0_r   [3][6];
  logic [55:0]        pp1_r   [3][6];
  logic [53:0]        pp2_r   [3][6];
  logic               neg_c_r [3][6];
  logic signed [31:0] rv_c_r  [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        for (int p = 0; p < 6; p++) begin
          pp0_r[k][p]   <= 56'(p_b_r[k][p][23:0]) * 56'(var_b_r[k]);
          pp1_r[k][p]   <= 56'(p_b_r[k][p][47:24]) * 56'(var_b_r[k]);
          pp2_r[k][p]   <= 54'(p_b_r[k][p][69:48]) * 54'(var_b_r[k]);
          neg_c_r[k][p] <= neg_b_r[k][p];
        end
      end
      rv_c_r <= rv_b_r;
    end
  end

  logic [103:0]       full [3][6];
  logic signed [56:0] term_r [3][6];
  logic signed [31:0] rv_d_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int p = 0; p < 6; p++) begin
        full[k][p] = 104'(pp0_r[k][p]) + (104'(pp1_r[k][p]) << 24)
                   + (104'(pp2_r[k][p]) << 48) + (104'(1) << 47);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        for (int p = 0; p < 6; p++) begin
          term_r[k][p] <= neg_c_r[k][p] ? -$signed({1'b0, full[k][p][103:48]})
                                        : $signed({1'b0, full[k][p][103:48]});
        end
      end
      rv_d_r <= rv_c_r;
    end
  end

  // final sum and saturation
  logic signed [58:0] csum [9];
  logic signed [47:0] cov  [9];
  out_word_t          out_nxt;
  out_word_t          out_r;

  always_comb begin
    for (int e = 0; e < 9; e++) begin
      csum[e] = 59'(term_r[0][PIDX[e]]) + 59'(term_r[1][PIDX[e]])
              + 59'(term_r[2][PIDX[e]]);
      if (csum[e] > C48_MAX) begin
        cov[e] = C48_MAX[47:0];
      end else if (csum[e] < C48_MIN) begin
        cov[e] = C48_MIN[47:0];
      end else begin
        cov[e] = csum[e][47:0];
      end
    end
    out_nxt.vec_out_x = rv_d_r[0];
    out_nxt.vec_out_y = rv_d_r[1];
    out_nxt.vec_out_z = rv_d_r[2];
    out_nxt.cov_00    = cov[0];
    out_nxt.cov_01    = cov[1];
    out_nxt.cov_02    = cov[2];
    out_nxt.cov_10    = cov[3];
    out_nxt.cov_11    = cov[4];
    out_nxt.cov_12    = cov[5];
    out_nxt.cov_20    = cov[6];
    out_nxt.cov_21    = cov[7];
    out_nxt.cov_22    = cov[8];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

@@ sim/ercov_checker.sv @@
// Checker: watches both channels, predicts rotated vector and covariance, compares words
`timescale 1ns / 1ps
module ercov_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  ercov_pkg::in_word_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  ercov_pkg::out_word_t out_data,
  output int                   fail_count,
  output int                   pending,
  output int                   checked
);
  import ercov_pkg::*;

  localparam longint UNIT    = 64'sd1073741824;
  localparam longint HALF    = 64'sd536870912;
  localparam longint GAIN_X0 = 64'sd652032874;
  localparam int     NSTAGE  = (CORDIC_STAGES_DEF > 32) ? 32 : CORDIC_STAGES_DEF;

  localparam longint ARCTAN [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
    5, 3, 1, 1, 0
  };

  typedef longint m9_t [9];

  out_word_t attitude_q[$];

  function automatic longint clamp_unit(input longint v);
    longint r;
    r = v;
    if (v > UNIT) r = UNIT;
    if (v < -UNIT) r = -UNIT;
    return r;
  endfunction

  function automatic longint sat_to(input longint v, input int bits);
    longint hi;
    longint r;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    r = v;
    if (v > hi) r = hi;
    if (v < -hi - 1) r = -hi - 1;
    return r;
  endfunction

  function automatic void sin_cos(input logic signed [15:0] a, output longint c,
                                  output longint s);
    longint ang, x, y, z, t;
    bit flip;
    ang = longint'(a);
    flip = 0;
    if (ang > 16384) begin
      ang -= 32768;
      flip = 1;
    end else if (ang < -16384) begin
      ang += 32768;
      flip = 1;
    end
    z = ang * 65536;
    x = GAIN_X0;
    y = 0;
    for (int i = 0; i < NSTAGE; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= ARCTAN[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += ARCTAN[i];
      end
      x = t;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clamp_unit(x);
    s = clamp_unit(y);
  endfunction

  function automatic void mat_prod(input m9_t a, input m9_t b, output m9_t r);
    longint acc;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += a[i*3+k] * b[k*3+j];
        r[i*3+j] = clamp_unit((acc + HALF) >>> 30);
      end
  endfunction

  function automatic void mat_apply(input m9_t m, input longint v [3],
                                    output longint r [3]);
    longint acc;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc += m[i*3+k] * v[k];
      r[i] = (acc + HALF) >>> 30;
    end
  endfunction

  function automatic longint variance_term(input longint ui, input longint uj,
                                           input logic [31:0] d);
    logic [127:0] ma, mb, p;
    longint r;
    ma = (ui < 0) ? -ui : ui;
    mb = (uj < 0) ? -uj : uj;
    p = ma * mb * {96'd0, d} + (128'd1 << 47);
    r = longint'(p >> 48);
    return ((ui < 0) != (uj < 0)) ? -r : r;
  endfunction

  function automatic out_word_t predict_attitude(input in_word_t w);
    longint ch, sh, cp, sp, cr, sr;
    m9_t p1, p2, p3, d1, d2, d3, tmp, rm, j1, j2, j3;
    longint v [3];
    longint rv [3];
    longint u [3][3];
    longint ut [3];
    logic [31:0] dv [3];
    longint acc;
    longint cov [9];
    out_word_t o;
    sin_cos(w.heading_angle, ch, sh);
    sin_cos(w.pitch_angle, cp, sp);
    sin_cos(w.roll_angle, cr, sr);
    v[0] = longint'(w.vec_in_x);
    v[1] = longint'(w.vec_in_y);
    v[2] = longint'(w.vec_in_z);
    dv[0] = w.heading_variance;
    dv[1] = w.pitch_variance;
    dv[2] = w.roll_variance;
    p3 = '{ch, sh, 0, -sh, ch, 0, 0, 0, UNIT};
    d3 = '{-sh, ch, 0, -ch, -sh, 0, 0, 0, 0};
    p1 = '{UNIT, 0, 0, 0, cp, sp, 0, -sp, cp};
    d1 = '{0, 0, 0, 0, -sp, cp, 0, -cp, -sp};
    p2 = '{cr, 0, sr, 0, UNIT, 0, -sr, 0, cr};
    d2 = '{-sr, 0, cr, 0, 0, 0, -cr, 0, -sr};
    mat_prod(d3, p1, tmp);
    mat_prod(tmp, p2, j1);
    mat_prod(p3, d1, tmp);
    mat_prod(tmp, p2, j2);
    mat_prod(p3, p1, tmp);
    mat_prod(tmp, d2, j3);
    mat_prod(tmp, p2, rm);
    mat_apply(rm, v, rv);
    mat_apply(j1, v, ut);
    u[0] = ut;
    mat_apply(j2, v, ut);
    u[1] = ut;
    mat_apply(j3, v, ut);
    u[2] = ut;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += variance_term(u[k][i], u[k][j], dv[k]);
        cov[i*3+j] = sat_to(acc, 48);
      end
    o.vec_out_x = 32'(sat_to(rv[0], 32));
    o.vec_out_y = 32'(sat_to(rv[1], 32));
    o.vec_out_z = 32'(sat_to(rv[2], 32));
    o.cov_00 = 48'(cov[0]);
    o.cov_01 = 48'(cov[1]);
    o.cov_02 = 48'(cov[2]);
    o.cov_10 = 48'(cov[3]);
    o.cov_11 = 48'(cov[4]);
    o.cov_12 = 48'(cov[5]);
    o.cov_20 = 48'(cov[6]);
    o.cov_21 = 48'(cov[7]);
    o.cov_22 = 48'(cov[8]);
    return o;
  endfunction

  function automatic void split_fields(input out_word_t w, output longint f [12]);
    f = '{w.vec_out_x, w.vec_out_y, w.vec_out_z, w.cov_00, w.cov_01, w.cov_02,
          w.cov_10, w.cov_11, w.cov_12, w.cov_20, w.cov_21, w.cov_22};
  endfunction

  localparam string FNAME [12] = '{"vec_out_x", "vec_out_y", "vec_out_z", "cov_00",
    "cov_01", "cov_02", "cov_10", "cov_11", "cov_12", "cov_20", "cov_21", "cov_22"};

  always @(posedge clk) begin
    out_word_t want;
    longint fe [12];
    longint fa [12];
    bit bad;
    if (!rst_n) begin
      fail_count = 0;
      checked = 0;
      attitude_q.delete();
      pending = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (attitude_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected output word %h", out_data);
        end else begin
          want = attitude_q.pop_front();
          split_fields(want, fe);
          split_fields(out_data, fa);
          bad = 0;
          for (int i = 0; i < 12; i++)
            if (fe[i] != fa[i]) begin
              bad = 1;
              if (fail_count < 10)
                $display("word %0d %s: expected %0d got %0d", checked, FNAME[i], fe[i], fa[i]);
            end
          if (bad) fail_count++;
          checked++;
        end
      end
      if (in_valid && !in_stall) attitude_q.push_back(predict_attitude(in_data));
      pending = attitude_q.size();
    end
  end

  final begin
    if (attitude_q.size() != 0) $display("%0d expected words never arrived", attitude_q.size());
  end
endmodule

@@ sim/testbench.sv @@
// Testbench top: clock, reset, stimulus, receiver stalls, watchdog and verdict
`timescale 1ns / 1ps
module testbench;
  import ercov_pkg::*;

  localparam int LATENCY   = CORDIC_STAGES_DEF + LAT_FIXED;
  localparam int N_RANDOM  = 1130;
  localparam int WATCHDOG  = 3000;
  localparam int HOLD_LEN  = 300;

  logic      clk = 0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;
  int        fail_count, pending, checked;
  bit        hold_req = 0;
  bit        held = 0;
  int        idle_cycles = 0;
  int        sent = 0;

  always #10 clk = ~clk;

  euler_rotation_error_covariance_top uut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  ercov_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .fail_count, .pending, .checked
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(input in_word_t w, input bit quiet);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  function automatic logic [31:0] pick_variance();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 65535);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_vec();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_word_t make_word(input logic [15:0] h, input logic [15:0] p,
      input logic [15:0] r, input logic [31:0] d, input logic [31:0] x,
      input logic [31:0] y, input logic [31:0] z);
    in_word_t w;
    w.heading_angle = h;
    w.pitch_angle = p;
    w.roll_angle = r;
    w.heading_variance = d;
    w.pitch_variance = d;
    w.roll_variance = d;
    w.vec_in_x = x;
    w.vec_in_y = y;
    w.vec_in_z = z;
    return w;
  endfunction

  // receiver stalls, with one long hold while the sender keeps offering
  initial begin
    int stall_left;
    bit quiet;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        out_stall <= 1'b1;
        held = 1;
        repeat (HOLD_LEN) @(posedge clk);
      end
      quiet = ($urandom_range(0, 999) < 5) ? ~quiet : quiet;
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < 35) begin
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [15:0] angs [7];
    in_word_t w;
    angs = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000, 16'h4001, 16'hC000, 16'hBFFF};
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: fold boundaries, field extremes, saturation, zero variance
    foreach (angs[i])
      send_word(make_word(angs[i], angs[(i+2)%7], angs[(i+4)%7], 32'hFFFF_FFFF,
                          32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000), 0);
    send_word(make_word(16'h0000, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0), 0);
    send_word(make_word(16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF), 0);
    send_word(make_word(16'h2000, 16'h2000, 16'h2000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF), 0);
    send_word(make_word(16'hE000, 16'h6000, 16'hA000, 32'hFFFF_FFFF, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000), 0);
    send_word(make_word(16'h8000, 16'h8000, 16'h8000, 32'h0, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h0), 1);
    send_word(make_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h1, 32'hFFFF_FFFF,
                        32'h1, 32'h0), 1);
    send_word(make_word(16'h1234, 16'hFEDC, 16'h0400, 32'h8000_0000, 32'h0123_4567,
                        32'hFEDC_BA98, 32'h0ACE_1357), 0);
    w = make_word(16'h1000, 16'h3000, 16'h5000, 32'd0, 32'h4000_0000, 32'h4000_0000,
                  32'hC000_0000);
    w.heading_variance = 32'hFFFF_FFFF;
    send_word(w, 0);
    w.heading_variance = 32'd0;
    w.roll_variance = 32'hFFFF_FFFF;
    send_word(w, 0);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 100) hold_req = 1;
      w.heading_angle    = 16'($urandom);
      w.pitch_angle      = 16'($urandom);
      w.roll_angle       = 16'($urandom);
      w.heading_variance = pick_variance();
      w.pitch_variance   = pick_variance();
      w.roll_variance    = pick_variance();
      w.vec_in_x         = pick_vec();
      w.vec_in_y         = pick_vec();
      w.vec_in_z         = pick_vec();
      send_word(w, (n / 150) % 3 == 2);
    end
    in_valid <= 1'b0;

    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("sent %0d attitude samples, checked %0d result words", sent, checked);
    $display("angles over all fold regions, variance and vector extremes, long output hold");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatching words", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
